@@ hw/rtl/camera_blob_range_and_bearing_assert.svh @@
// Assertion macros for the camera blob range and bearing block.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef CAMERA_BLOB_RANGE_AND_BEARING_ASSERT_SVH
`define CAMERA_BLOB_RANGE_AND_BEARING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cbrb_pkg.sv @@
// Package for the camera blob range and bearing block.
// Holds widths, calibration tables, codes and state types; depends on nothing.
package cbrb_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned ROM_STORED        = 16;

  localparam int unsigned PIX_W      = 9;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned WCAL_W     = 6;
  localparam int unsigned RANGE_W    = 12;
  localparam int unsigned OFFSET_W   = 10;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ROM_PIX_W  = 7;
  localparam int unsigned FOCUS_W    = 13;
  localparam int unsigned DIV_NUM_W  = 19;
  localparam int unsigned DIV_DEN_W  = 10;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = WCAL_W;

  localparam logic [CFG_IDX_W-1:0] REG_SMALL_W = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_W = 1'd1;

  localparam logic [WCAL_W-1:0]  SMALL_W_RESET = 6'd5;
  localparam logic [WCAL_W-1:0]  LARGE_W_RESET = 6'd10;
  localparam logic [PIX_W-1:0]   MIN_X         = 9'd10;
  localparam logic [COLOR_W-1:0] SMALL_LIMIT   = 4'd4;
  localparam logic [RANGE_W-1:0] TRACK_START   = 12'd1000;
  localparam logic [RANGE_W-1:0] RANGE_MAX     = 12'd4095;
  localparam logic [PIX_W+1:0]   CENTRE_2X     = 11'd315;

  localparam int unsigned ROM_DIST_BASE = 25;
  localparam int unsigned ROM_DIST_STEP = 5;

  localparam logic [ROM_PIX_W-1:0] SMALL_ROM [ROM_STORED] = '{
    7'd36, 7'd30, 7'd28, 7'd24, 7'd22, 7'd20, 7'd20, 7'd16,
    7'd16, 7'd14, 7'd14, 7'd14, 7'd12, 7'd12, 7'd12, 7'd12
  };
  localparam logic [ROM_PIX_W-1:0] LARGE_ROM [ROM_STORED] = '{
    7'd78, 7'd76, 7'd70, 7'd64, 7'd56, 7'd52, 7'd48, 7'd43,
    7'd40, 7'd38, 7'd36, 7'd30, 7'd28, 7'd24, 7'd22, 7'd20
  };

  typedef enum logic [KIND_W-1:0] {
    KIND_BLOB    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FOCUS,
    S_DIVIDE,
    S_NEXT,
    S_EMIT_BLOB,
    S_EMIT_SUM,
    S_EMIT_EMPTY
  } state_t;

  typedef enum logic [1:0] {
    OP_FOCUS,
    OP_RANGE,
    OP_QUOT,
    OP_OFFSET
  } op_t;

  // Entries beyond the stored table repeat the last stored pixel width.
  function automatic logic [ROM_PIX_W-1:0] rom_pix(input logic is_small, input int unsigned i);
    logic [3:0] k;
    k = (i < ROM_STORED) ? 4'(i) : 4'(ROM_STORED - 1);
    return is_small ? SMALL_ROM[k] : LARGE_ROM[k];
  endfunction

  function automatic logic [FOCUS_W-1:0] rom_pd(input logic is_small, input int unsigned i);
    int unsigned prod;
    prod = int'(rom_pix(is_small, i)) * (ROM_DIST_BASE + ROM_DIST_STEP * i);
    return prod[FOCUS_W-1:0];
  endfunction

endpackage

@@ hw/rtl/cbrb_in_if.sv @@
// Blob input channel: valid, ready and one detected blob per beat.
// Depends on cbrb_pkg for field widths.
interface cbrb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         empty_frame;
  logic [cbrb_pkg::PIX_W-1:0]   x_position;
  logic [cbrb_pkg::PIX_W-1:0]   width_pixels;
  logic [cbrb_pkg::COLOR_W-1:0] color_code;
  logic                         last_block;

  modport source (
    output valid, empty_frame, x_position, width_pixels, color_code, last_block,
    input  ready
  );
  modport sink (
    input  valid, empty_frame, x_position, width_pixels, color_code, last_block,
    output ready
  );
endinterface

@@ hw/rtl/cbrb_out_if.sv @@
// Report output channel: valid, ready and one report per beat.
// Depends on cbrb_pkg for field widths.
interface cbrb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [cbrb_pkg::KIND_W-1:0]   report_kind;
  logic        [cbrb_pkg::COLOR_W-1:0]  report_color;
  logic        [cbrb_pkg::RANGE_W-1:0]  range_cm;
  logic signed [cbrb_pkg::OFFSET_W-1:0] offset_cm;
  logic                                 last_result;

  modport source (
    output valid, report_kind, report_color, range_cm, offset_cm, last_result,
    input  ready
  );
  modport sink (
    input  valid, report_kind, report_color, range_cm, offset_cm, last_result,
    output ready
  );
endinterface

@@ hw/rtl/camera_blob_range_and_bearing.sv @@
// Top level of the camera blob range and bearing block.
// Depends on cbrb_pkg, cbrb_in_if, cbrb_out_if and the assertion macro header.
//
// in_blob carries one blob beat per detected blob, or an empty-frame beat.
// out_rep carries reports: a blob report for each blob with x above 10,
// and a nearest-blob summary when a beat is marked last or the frame is empty.
// cfg_we, cfg_index and cfg_wdata write the two calibration widths.
// A blob is ranged by a sequencer around one restoring divider: an accept step,
// a scan over entries 1 to TABLE_ENTRIES-2 of the calibration table, a load step,
// four divisions (focus, range, scale and offset) each followed by a dispatch
// step, and an emit step. A blob narrower than its calibration width skips the
// offset division, and a frame-ending blob adds a step for the summary. Blobs
// with a zero width go from the accept step straight to the emit step, and an
// empty frame emits the empty report and then the summary.
// in_blob.ready is high only while
// the sequencer is idle. Results pass through a single output register, so
// the next beat is accepted while the last report still waits; when the
// receiver stalls, a further report waits in the sequencer until it is taken.
// Reset empties the output register, restores the calibration widths to
// 5 and 10 cm and clears the nearest-blob tracker.
`include "camera_blob_range_and_bearing_assert.svh"

module camera_blob_range_and_bearing #(
  parameter int unsigned TABLE_ENTRIES = cbrb_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cbrb_in_if.sink                           in_blob,
  cbrb_out_if.source                        out_rep,
  input  logic                              cfg_we,
  input  logic [cbrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbrb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(TABLE_ENTRIES - 2);
  localparam logic [IDX_W-1:0] SCAN_START = IDX_W'(1);
  localparam logic HAS_SCAN = (TABLE_ENTRIES > 2);

  localparam int unsigned NUM_W = cbrb_pkg::DIV_NUM_W;
  localparam int unsigned DEN_W = cbrb_pkg::DIV_DEN_W;
  localparam int unsigned CNT_W = cbrb_pkg::DIV_CNT_W;

  cbrb_pkg::state_t state_r, state_nxt;
  cbrb_pkg::op_t    op_r, op_nxt;

  logic [cbrb_pkg::WCAL_W-1:0]  small_w_r, large_w_r;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [IDX_W-1:0]             sel_r, sel_nxt;
  logic [cbrb_pkg::PIX_W-1:0]   x_r, x_nxt;
  logic [cbrb_pkg::PIX_W-1:0]   w_r, w_nxt;
  logic [cbrb_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                         last_r, last_nxt;
  logic                         small_r, small_nxt;
  logic [cbrb_pkg::WCAL_W-1:0]  wcal_r, wcal_nxt;
  logic [cbrb_pkg::RANGE_W-1:0] range_r, range_nxt;
  logic signed [cbrb_pkg::OFFSET_W-1:0] offset_r, offset_nxt;

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [cbrb_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [cbrb_pkg::COLOR_W-1:0] out_color_r, out_color_nxt;
  logic [cbrb_pkg::RANGE_W-1:0] out_range_r, out_range_nxt;
  logic signed [cbrb_pkg::OFFSET_W-1:0] out_offset_r, out_offset_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [cbrb_pkg::RANGE_W-1:0] near_range_r, near_range_nxt;
  logic [cbrb_pkg::COLOR_W-1:0] near_color_r, near_color_nxt;
  logic signed [cbrb_pkg::OFFSET_W-1:0] near_offset_r, near_offset_nxt;
  logic                         near_found_r, near_found_nxt;

  logic                         out_free;
  logic                         small_in;
  logic [cbrb_pkg::WCAL_W-1:0]  wcal_in;
  logic [cbrb_pkg::PIX_W-1:0]   lo_mid, hi_mid;
  logic [DEN_W:0]               div_shift;
  logic                         div_ge;
  logic                         div_bit;
  logic [NUM_W-1:0]             prod;
  logic [cbrb_pkg::PIX_W+1:0]   x2;
  logic                         x_neg;
  logic [cbrb_pkg::PIX_W+1:0]   cen_mag;
  logic [cbrb_pkg::OFFSET_W-1:0] off_mag;

  assign out_free = !out_valid_r || out_rep.ready;
  assign in_blob.ready = (state_r == cbrb_pkg::S_IDLE);

  assign small_in = (in_blob.color_code < cbrb_pkg::SMALL_LIMIT);
  assign wcal_in  = small_in ? small_w_r : large_w_r;

  assign lo_mid = cbrb_pkg::PIX_W'(({1'b0, cbrb_pkg::rom_pix(small_r, int'(idx_r))} +
                   {1'b0, cbrb_pkg::rom_pix(small_r, int'(idx_r) + 1)}) >> 1);
  assign hi_mid = cbrb_pkg::PIX_W'(({1'b0, cbrb_pkg::rom_pix(small_r, int'(idx_r))} +
                   {1'b0, cbrb_pkg::rom_pix(small_r, int'(idx_r) - 1)}) >> 1);

  assign div_shift = {rem_r, num_r[NUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, den_r});
  assign div_bit   = div_ge;

  assign prod = NUM_W'(wcal_r) * NUM_W'(num_r[cbrb_pkg::FOCUS_W-1:0]);

  assign x2      = {1'b0, x_r, 1'b0};
  assign x_neg   = (x2 > cbrb_pkg::CENTRE_2X);
  assign cen_mag = x_neg ? (x2 - cbrb_pkg::CENTRE_2X) : (cbrb_pkg::CENTRE_2X - x2);
  assign off_mag = {1'b0, num_r[cbrb_pkg::OFFSET_W-2:0]};

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    sel_nxt         = sel_r;
    x_nxt           = x_r;
    w_nxt           = w_r;
    color_nxt       = color_r;
    last_nxt        = last_r;
    small_nxt       = small_r;
    wcal_nxt        = wcal_r;
    range_nxt       = range_r;
    offset_nxt      = offset_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_rep.ready;
    out_kind_nxt    = out_kind_r;
    out_color_nxt   = out_color_r;
    out_range_nxt   = out_range_r;
    out_offset_nxt  = out_offset_r;
    out_last_nxt    = out_last_r;
    near_range_nxt  = near_range_r;
    near_color_nxt  = near_color_r;
    near_offset_nxt = near_offset_r;
    near_found_nxt  = near_found_r;

    unique case (state_r)
      cbrb_pkg::S_IDLE: begin
        if (in_blob.valid) begin
          x_nxt     = in_blob.x_position;
          w_nxt     = in_blob.width_pixels;
          color_nxt = in_blob.color_code;
          last_nxt  = in_blob.last_block;
          small_nxt = small_in;
          wcal_nxt  = wcal_in;
          if (in_blob.empty_frame) begin
            state_nxt = cbrb_pkg::S_EMIT_EMPTY;
          end else if (in_blob.x_position > cbrb_pkg::MIN_X) begin
            if (wcal_in == '0 || in_blob.width_pixels == '0) begin
              range_nxt  = cbrb_pkg::RANGE_MAX;
              offset_nxt = '0;
              state_nxt  = cbrb_pkg::S_EMIT_BLOB;
            end else begin
              sel_nxt = (in_blob.width_pixels > cbrb_pkg::PIX_W'(cbrb_pkg::rom_pix(small_in, 0)))
                        ? '0 : LAST_IDX;
              idx_nxt   = SCAN_START;
              state_nxt = HAS_SCAN ? cbrb_pkg::S_SCAN : cbrb_pkg::S_FOCUS;
            end
          end else if (in_blob.last_block) begin
            state_nxt = cbrb_pkg::S_EMIT_SUM;
          end
        end
      end
      cbrb_pkg::S_SCAN: begin
        if (w_r > lo_mid && w_r < hi_mid) begin
          sel_nxt = idx_r;
        end
        if (idx_r == SCAN_END) begin
          state_nxt = cbrb_pkg::S_FOCUS;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      cbrb_pkg::S_FOCUS: begin
        num_nxt   = NUM_W'(cbrb_pkg::rom_pd(small_r, int'(sel_r)));
        den_nxt   = DEN_W'(wcal_r);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        op_nxt    = cbrb_pkg::OP_FOCUS;
        state_nxt = cbrb_pkg::S_DIVIDE;
      end
      cbrb_pkg::S_DIVIDE: begin
        rem_nxt = div_ge ? DEN_W'(div_shift - {1'b0, den_r}) : div_shift[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], div_bit};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = cbrb_pkg::S_NEXT;
        end
      end
      cbrb_pkg::S_NEXT: begin
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = cbrb_pkg::S_DIVIDE;
        unique case (op_r)
          cbrb_pkg::OP_FOCUS: begin
            num_nxt = prod;
            den_nxt = DEN_W'(w_r);
            op_nxt  = cbrb_pkg::OP_RANGE;
          end
          cbrb_pkg::OP_RANGE: begin
            range_nxt = (num_r > NUM_W'(cbrb_pkg::RANGE_MAX))
                        ? cbrb_pkg::RANGE_MAX : num_r[cbrb_pkg::RANGE_W-1:0];
            num_nxt = NUM_W'(w_r);
            den_nxt = DEN_W'(wcal_r);
            op_nxt  = cbrb_pkg::OP_QUOT;
          end
          cbrb_pkg::OP_QUOT: begin
            if (num_r == '0) begin
              offset_nxt = '0;
              state_nxt  = cbrb_pkg::S_EMIT_BLOB;
            end else begin
              num_nxt = NUM_W'(cen_mag);
              den_nxt = {num_r[cbrb_pkg::PIX_W-1:0], 1'b0};
              op_nxt  = cbrb_pkg::OP_OFFSET;
            end
          end
          cbrb_pkg::OP_OFFSET: begin
            offset_nxt = x_neg ? (cbrb_pkg::OFFSET_W'(0) - $signed(off_mag))
                               : $signed(off_mag);
            state_nxt  = cbrb_pkg::S_EMIT_BLOB;
          end
        endcase
      end
      cbrb_pkg::S_EMIT_BLOB: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = cbrb_pkg::KIND_BLOB;
          out_color_nxt  = color_r;
          out_range_nxt  = range_r;
          out_offset_nxt = offset_r;
          out_last_nxt   = !last_r;
          if (range_r < near_range_r) begin
            near_range_nxt  = range_r;
            near_color_nxt  = color_r;
            near_offset_nxt = offset_r;
            near_found_nxt  = 1'b1;
          end
          state_nxt = last_r ? cbrb_pkg::S_EMIT_SUM : cbrb_pkg::S_IDLE;
        end
      end
      cbrb_pkg::S_EMIT_SUM: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = cbrb_pkg::KIND_SUMMARY;
          out_color_nxt   = near_found_r ? near_color_r : '0;
          out_range_nxt   = near_found_r ? near_range_r : '0;
          out_offset_nxt  = near_found_r ? near_offset_r : '0;
          out_last_nxt    = 1'b1;
          near_range_nxt  = cbrb_pkg::TRACK_START;
          near_color_nxt  = '0;
          near_offset_nxt = '0;
          near_found_nxt  = 1'b0;
          state_nxt       = cbrb_pkg::S_IDLE;
        end
      end
      cbrb_pkg::S_EMIT_EMPTY: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = cbrb_pkg::KIND_EMPTY;
          out_color_nxt   = '0;
          out_range_nxt   = '0;
          out_offset_nxt  = '0;
          out_last_nxt    = 1'b0;
          near_range_nxt  = cbrb_pkg::TRACK_START;
          near_color_nxt  = '0;
          near_offset_nxt = '0;
          near_found_nxt  = 1'b0;
          state_nxt       = cbrb_pkg::S_EMIT_SUM;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= cbrb_pkg::S_IDLE;
      out_valid_r   <= 1'b0;
      small_w_r     <= cbrb_pkg::SMALL_W_RESET;
      large_w_r     <= cbrb_pkg::LARGE_W_RESET;
      near_range_r  <= cbrb_pkg::TRACK_START;
      near_color_r  <= '0;
      near_offset_r <= '0;
      near_found_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      near_range_r  <= near_range_nxt;
      near_color_r  <= near_color_nxt;
      near_offset_r <= near_offset_nxt;
      near_found_r  <= near_found_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cbrb_pkg::REG_SMALL_W: small_w_r <= cfg_wdata;
          cbrb_pkg::REG_LARGE_W: large_w_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    sel_r        <= sel_nxt;
    x_r          <= x_nxt;
    w_r          <= w_nxt;
    color_r      <= color_nxt;
    last_r       <= last_nxt;
    small_r      <= small_nxt;
    wcal_r       <= wcal_nxt;
    range_r      <= range_nxt;
    offset_r     <= offset_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    out_kind_r   <= out_kind_nxt;
    out_color_r  <= out_color_nxt;
    out_range_r  <= out_range_nxt;
    out_offset_r <= out_offset_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_rep.valid        = out_valid_r;
  assign out_rep.report_kind  = out_kind_r;
  assign out_rep.report_color = out_color_r;
  assign out_rep.range_cm     = out_range_r;
  assign out_rep.offset_cm    = out_offset_r;
  assign out_rep.last_result  = out_last_r;

  `CBRB_ASSERT_NOW(a_div_rem_below_den, state_r == cbrb_pkg::S_DIVIDE, rem_r < den_r,
                   "Divider remainder is not below the divisor.")
  `CBRB_ASSERT_NOW(a_track_below_start, near_found_r, near_range_r < cbrb_pkg::TRACK_START,
                   "Tracked nearest blob has a range at or above the start value.")
  `CBRB_ASSERT_NOW(a_summary_is_last,
                   out_valid_r && out_kind_r == cbrb_pkg::KIND_SUMMARY, out_last_r,
                   "A summary beat is not marked as the last result.")
  `CBRB_ASSERT_NEXT(a_empty_goes_to_emit,
                    in_blob.valid && in_blob.ready && in_blob.empty_frame,
                    state_r == cbrb_pkg::S_EMIT_EMPTY,
                    "An empty-frame beat did not lead to the empty report.")

endmodule

@@ verif/tb_camera_blob_range_and_bearing.sv @@
// Testbench for camera_blob_range_and_bearing: drives blob beats, predicts every report
// and checks each one in order. Depends on cbrb_pkg, cbrb_in_if, cbrb_out_if and the RTL.
`timescale 1ns / 1ps

module tb_camera_blob_range_and_bearing;

  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 200;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned PHASES          = 7;
  localparam int unsigned ITEMS_PER_PHASE = 190;

  localparam int unsigned TBL_N        = 16;
  localparam int unsigned TBL_STORED   = 16;
  localparam int unsigned X_FLOOR      = 10;
  localparam int unsigned SMALL_COLORS = 4;
  localparam int unsigned TRACK_INIT   = 1000;
  localparam int unsigned RANGE_CAP    = 4095;
  localparam int unsigned DIST_BASE    = 25;
  localparam int unsigned DIST_STEP    = 5;
  localparam int          CENTRE_X2    = 315;
  localparam int          OFFSET_HI    = 511;
  localparam int          OFFSET_LO    = -512;

  localparam int unsigned SMALL_PIX [TBL_STORED] = '{
    36, 30, 28, 24, 22, 20, 20, 16, 16, 14, 14, 14, 12, 12, 12, 12
  };
  localparam int unsigned LARGE_PIX [TBL_STORED] = '{
    78, 76, 70, 64, 56, 52, 48, 43, 40, 38, 36, 30, 28, 24, 22, 20
  };

  typedef struct packed {
    cbrb_pkg::kind_t   kind;
    logic [3:0]        color;
    logic [11:0]       range_cm;
    logic signed [9:0] offset_cm;
    logic              last_res;
  } report_t;

  class range_report_board;
    logic [5:0]        small_w;
    logic [5:0]        large_w;
    logic [11:0]       near_range;
    logic [3:0]        near_color;
    logic signed [9:0] near_offset;
    logic              near_found;
    report_t           due_reports[$];
    int                errors;

    function new();
      small_w = 6'd5;
      large_w = 6'd10;
      errors  = 0;
      clear_track();
    endfunction

    function void clear_track();
      near_range  = 12'(TRACK_INIT);
      near_color  = '0;
      near_offset = '0;
      near_found  = 1'b0;
    endfunction

    function report_t make_report(cbrb_pkg::kind_t kind, logic [3:0] color, logic [11:0] rng,
                                  logic signed [9:0] off, logic last_res);
      report_t r;
      r.kind      = kind;
      r.color     = color;
      r.range_cm  = rng;
      r.offset_cm = off;
      r.last_res  = last_res;
      return r;
    endfunction

    function int unsigned pix_at(logic small_cls, int unsigned i);
      int unsigned k;
      k = (i < TBL_STORED) ? i : TBL_STORED - 1;
      return small_cls ? SMALL_PIX[k] : LARGE_PIX[k];
    endfunction

    function void note_blob(logic empty, logic [8:0] x, logic [8:0] w, logic [3:0] color,
                            logic last);
      logic        small_cls;
      int unsigned wcal, focus, rng, q, lo, hi, i;
      int          off;
      if (empty) begin
        due_reports.push_back(make_report(cbrb_pkg::KIND_EMPTY, '0, '0, '0, 1'b0));
        due_reports.push_back(make_report(cbrb_pkg::KIND_SUMMARY, '0, '0, '0, 1'b1));
        clear_track();
        return;
      end
      if (x > X_FLOOR) begin
        small_cls = color < SMALL_COLORS;
        wcal = small_cls ? small_w : large_w;
        if (wcal == 0 || w == 0) begin
          rng = RANGE_CAP;
          off = 0;
        end else begin
          focus = pix_at(small_cls, TBL_N - 1) * (DIST_BASE + DIST_STEP * (TBL_N - 1)) / wcal;
          if (w > pix_at(small_cls, 0)) focus = pix_at(small_cls, 0) * DIST_BASE / wcal;
          for (i = 1; i + 1 < TBL_N; i++) begin
            lo = (pix_at(small_cls, i) + pix_at(small_cls, i + 1)) / 2;
            hi = (pix_at(small_cls, i) + pix_at(small_cls, i - 1)) / 2;
            if (w > lo && w < hi)
              focus = pix_at(small_cls, i) * (DIST_BASE + DIST_STEP * i) / wcal;
          end
          rng = wcal * focus / w;
          if (rng > RANGE_CAP) rng = RANGE_CAP;
          q = w / wcal;
          if (q == 0) begin
            off = 0;
          end else begin
            off = (CENTRE_X2 - 2 * int'(x)) / (2 * int'(q));
            if (off > OFFSET_HI) off = OFFSET_HI;
            if (off < OFFSET_LO) off = OFFSET_LO;
          end
        end
        if (rng < near_range) begin
          near_range  = 12'(rng);
          near_color  = color;
          near_offset = 10'(off);
          near_found  = 1'b1;
        end
        due_reports.push_back(make_report(cbrb_pkg::KIND_BLOB, color, 12'(rng), 10'(off),
                                          !last));
      end
      if (last) begin
        if (near_found)
          due_reports.push_back(make_report(cbrb_pkg::KIND_SUMMARY, near_color, near_range,
                                            near_offset, 1'b1));
        else
          due_reports.push_back(make_report(cbrb_pkg::KIND_SUMMARY, '0, '0, '0, 1'b1));
        clear_track();
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (due_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, actual kind %0d color %0d range %0d offset %0d last %0d",
                 $time, got.kind, got.color, got.range_cm, got.offset_cm, got.last_res);
        return;
      end
      want = due_reports.pop_front();
      if (got.kind !== want.kind || got.color !== want.color || got.range_cm !== want.range_cm ||
          got.offset_cm !== want.offset_cm || got.last_res !== want.last_res) begin
        errors++;
        $display("%0t: report mismatch, expected kind %0d color %0d range %0d offset %0d last %0d",
                 $time, want.kind, want.color, want.range_cm, want.offset_cm, want.last_res);
        $display("%0t:                  actual kind %0d color %0d range %0d offset %0d last %0d",
                 $time, got.kind, got.color, got.range_cm, got.offset_cm, got.last_res);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [cbrb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cbrb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic       blob_valid = 1'b0;
  logic       blob_empty = 1'b0;
  logic [8:0] blob_x = '0;
  logic [8:0] blob_w = '0;
  logic [3:0] blob_color = '0;
  logic       blob_last = 1'b0;
  logic       rep_ready = 1'b0;

  logic        idle_on = 1'b1;
  logic [7:0]  hold_seq = '0;
  logic [7:0]  hold_seen = '0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;

  range_report_board board;

  cbrb_in_if  in_ch ();
  cbrb_out_if out_ch ();

  assign in_ch.valid        = blob_valid;
  assign in_ch.empty_frame  = blob_empty;
  assign in_ch.x_position   = blob_x;
  assign in_ch.width_pixels = blob_w;
  assign in_ch.color_code   = blob_color;
  assign in_ch.last_block   = blob_last;
  assign out_ch.ready       = rep_ready;

  camera_blob_range_and_bearing dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_blob   (in_ch),
    .out_rep   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      rep_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rep_ready <= (hold_left == 1);
    end else if (!idle_on) begin
      rep_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rep_ready  <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 16);
      rep_ready  <= 1'b0;
    end else begin
      rep_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    report_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_blob(in_ch.empty_frame, in_ch.x_position, in_ch.width_pixels,
                        in_ch.color_code, in_ch.last_block);
      if (out_ch.valid && out_ch.ready) begin
        got.kind      = cbrb_pkg::kind_t'(out_ch.report_kind);
        got.color     = out_ch.report_color;
        got.range_cm  = out_ch.range_cm;
        got.offset_cm = out_ch.offset_cm;
        got.last_res  = out_ch.last_result;
        board.check_report(got);
      end
    end
  end

  task automatic send_blob(input logic empty, input logic [8:0] x, input logic [8:0] w,
                           input logic [3:0] color, input logic last);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      blob_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    blob_valid <= 1'b1;
    blob_empty <= empty;
    blob_x     <= x;
    blob_w     <= w;
    blob_color <= color;
    blob_last  <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_frame();
    int unsigned pick, n, k, wmode;
    logic [8:0]  x, w;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_blob(1'b1, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end else if (pick < 18) begin
      send_blob(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                9'($urandom_range(0, 511)), 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)));
    end else begin
      n = $urandom_range(1, 5);
      for (k = 0; k < n; k++) begin
        x = ($urandom_range(0, 99) < 85) ? 9'($urandom_range(11, 511))
                                         : 9'($urandom_range(0, 10));
        wmode = $urandom_range(0, 9);
        if (wmode < 6)       w = 9'($urandom_range(10, 80));
        else if (wmode == 6) w = 9'd0;
        else if (wmode == 7) w = 9'($urandom_range(1, 9));
        else                 w = 9'($urandom_range(0, 511));
        send_blob(1'b0, x, w, 4'($urandom_range(0, 15)), k == n - 1);
      end
    end
  endtask

  task automatic drain(input int unsigned settle);
    blob_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic program_widths(input logic [5:0] small_w, input logic [5:0] large_w);
    cfg_we    <= 1'b1;
    cfg_index <= cbrb_pkg::REG_SMALL_W;
    cfg_wdata <= small_w;
    @(posedge clk);
    cfg_index <= cbrb_pkg::REG_LARGE_W;
    cfg_wdata <= large_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.small_w = small_w;
    board.large_w = large_w;
  endtask

  initial begin : stimulus
    int unsigned phase, target;
    logic [5:0]  sw, lw;
    logic        held, paused;
    board  = new();
    held   = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_blob(1'b1, 511, 511, 15, 1'b1);
    send_blob(1'b0, 0, 511, 15, 1'b0);
    send_blob(1'b0, 10, 40, 2, 1'b1);
    send_blob(1'b0, 11, 36, 0, 1'b0);
    send_blob(1'b0, 511, 37, 1, 1'b0);
    send_blob(1'b0, 157, 20, 3, 1'b0);
    send_blob(1'b0, 158, 78, 4, 1'b0);
    send_blob(1'b0, 300, 0, 8, 1'b0);
    send_blob(1'b0, 200, 9, 12, 1'b0);
    send_blob(1'b0, 400, 511, 15, 1'b1);
    send_blob(1'b0, 200, 1, 0, 1'b1);
    send_blob(1'b0, 50, 24, 0, 1'b0);
    send_blob(1'b0, 60, 24, 1, 1'b1);
    send_blob(1'b1, 0, 0, 0, 1'b0);
    send_blob(1'b0, 11, 511, 4, 1'b1);
    send_blob(1'b0, 5, 100, 7, 1'b1);
    send_blob(1'b0, 256, 12, 3, 1'b0);
    send_blob(1'b0, 100, 20, 15, 1'b1);
    send_blob(1'b0, 157, 55, 9, 1'b0);
    send_blob(1'b0, 158, 55, 9, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain(SETTLE_CYCLES);
        case (phase)
          1:       begin sw = 6'd63; lw = 6'd63; end
          2:       begin sw = 6'd1;  lw = 6'd1;  end
          3:       begin sw = 6'd0;  lw = 6'd63; end
          4:       begin sw = 6'd63; lw = 6'd0;  end
          default: begin sw = 6'($urandom_range(1, 63)); lw = 6'($urandom_range(1, 63)); end
        endcase
        program_widths(sw, lw);
      end
      if (phase == PHASES - 1) idle_on <= 1'b0;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if (phase == 1 && !held && items_sent + ITEMS_PER_PHASE / 2 >= target) begin
          hold_seq <= hold_seq + 8'd1;
          held = 1'b1;
        end
        if (phase == 2 && !paused && items_sent + ITEMS_PER_PHASE / 2 >= target) begin
          drain(0);
          paused = 1'b1;
        end
        send_random_frame();
      end
    end

    drain(SETTLE_CYCLES);
    if (board.errors == 0 && board.due_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
